// ----- hw/rtl/clrc_pkg.sv -----
// Shared constants and item types for the console log ring capture block.
package clrc_pkg;

   // Ring size in bytes: a power of two from 16 to 512.
   localparam int RING_BYTES = 512;

   // An item moves at most eight bytes, one per byte lane.
   localparam int LANES      = 8;
   localparam int LANE_W     = $clog2(LANES);
   localparam int BYTE_CNT_W = 4;

   localparam int POS_W      = $clog2(RING_BYTES);
   localparam int ROWS       = RING_BYTES / LANES;
   localparam int ROW_W      = $clog2(ROWS);
   localparam int HELD_W     = $clog2(RING_BYTES + 1);

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic {
      ACTION_APPEND = 1'b0,
      ACTION_DUMP   = 1'b1
   } clrc_action_type;

   typedef struct packed {
      logic                  action;
      logic [63:0]           data_bytes;
      logic [BYTE_CNT_W-1:0] byte_count;
   } clrc_req_type;

   typedef struct packed {
      logic [63:0]           chunk_data;
      logic [BYTE_CNT_W-1:0] chunk_bytes;
      logic                  chunk_last;
   } clrc_rsp_type;

   // A classified command as it waits in the queue; an append's count is already 1 to 8.
   typedef struct packed {
      logic                  dump;
      logic [63:0]           data;
      logic [BYTE_CNT_W-1:0] count;
   } clrc_cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } clrc_queue_status_type;

   typedef enum logic {
      BACK_IDLE,
      BACK_DUMP
   } clrc_back_state_type;

endpackage

// ----- hw/rtl/clrc_front.sv -----
// Front end: accepts request items, clamps the byte count and drops empty appends.
module clrc_front (
   input  logic                           start,
   input  clrc_pkg::clrc_req_type         req_payload,
   input  clrc_pkg::clrc_queue_status_type queue_status,
   output logic                           busy,
   output logic                           push,
   output clrc_pkg::clrc_cmd_type         push_cmd
);

   logic                            is_dump;
   logic [clrc_pkg::BYTE_CNT_W-1:0] clamped_count;

   always_comb begin
      is_dump = (req_payload.action == clrc_pkg::ACTION_DUMP);
      // Counts above eight mean a full item.
      if (req_payload.byte_count > clrc_pkg::BYTE_CNT_W'(clrc_pkg::LANES)) begin
         clamped_count = clrc_pkg::BYTE_CNT_W'(clrc_pkg::LANES);
      end else begin
         clamped_count = req_payload.byte_count;
      end
   end

   assign busy = queue_status.full;

   // An append of zero bytes is accepted but changes nothing, so it never enters the queue.
   assign push = start && !queue_status.full && (is_dump || (clamped_count != '0));

   always_comb begin
      push_cmd.dump  = is_dump;
      push_cmd.data  = req_payload.data_bytes;
      push_cmd.count = clamped_count;
   end

endmodule

// ----- hw/rtl/clrc_queue.sv -----
// Short command queue between the front end and the ring engine.
module clrc_queue (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            push,
   input  clrc_pkg::clrc_cmd_type          push_cmd,
   input  logic                            pop,
   output clrc_pkg::clrc_cmd_type          head_cmd,
   output clrc_pkg::clrc_queue_status_type status
);

   clrc_pkg::clrc_cmd_type          entry_ff [clrc_pkg::QUEUE_DEPTH];
   logic [clrc_pkg::QPTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [clrc_pkg::QPTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [clrc_pkg::QCNT_W-1:0]     count_ff, count_in;
   logic                            do_push;
   logic                            do_pop;

   assign status.full  = (count_ff == clrc_pkg::QCNT_W'(clrc_pkg::QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head_cmd     = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ----- hw/rtl/clrc_back.sv -----
// Ring engine: eight byte-lane banks, append writes and chunked dump reads.
module clrc_back (
   input  logic                            clock,
   input  logic                            reset,
   input  clrc_pkg::clrc_queue_status_type queue_status,
   input  clrc_pkg::clrc_cmd_type          head_cmd,
   output logic                            pop,
   output logic                            rsp_valid,
   output clrc_pkg::clrc_rsp_type          rsp_payload
);

   localparam int POS_W  = clrc_pkg::POS_W;
   localparam int LANE_W = clrc_pkg::LANE_W;
   localparam int HELD_W = clrc_pkg::HELD_W;
   localparam int BCW    = clrc_pkg::BYTE_CNT_W;

   clrc_pkg::clrc_back_state_type state_ff, state_in;

   logic [POS_W-1:0]  wr_pos_ff, wr_pos_in;
   logic [HELD_W-1:0] held_ff, held_in;
   logic [POS_W-1:0]  rd_base_ff, rd_base_in;
   logic [HELD_W-1:0] remain_ff, remain_in;

   logic [LANE_W-1:0] chunk_lo_ff;
   logic [BCW-1:0]    take_ff;
   logic              last_ff;
   logic              out_valid_ff;

   logic              wr_active;
   logic              dump_start;
   logic              rd_active;
   logic [BCW-1:0]    take;
   logic              last_chunk;
   logic [HELD_W:0]   held_sum;
   logic [7:0]        rd_q_ff [clrc_pkg::LANES];

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         clrc_pkg::BACK_IDLE: begin
            if (!queue_status.empty && head_cmd.dump && (held_ff != '0)) begin
               state_in = clrc_pkg::BACK_DUMP;
            end
         end
         clrc_pkg::BACK_DUMP: begin
            if (last_chunk) begin
               state_in = clrc_pkg::BACK_IDLE;
            end
         end
         default: state_in = clrc_pkg::BACK_IDLE;
      endcase
   end

   // Control outputs.
   always_comb begin
      pop        = 1'b0;
      wr_active  = 1'b0;
      dump_start = 1'b0;
      rd_active  = 1'b0;
      unique case (state_ff)
         clrc_pkg::BACK_IDLE: begin
            pop        = !queue_status.empty;
            wr_active  = !queue_status.empty && !head_cmd.dump;
            dump_start = !queue_status.empty && head_cmd.dump && (held_ff != '0);
         end
         clrc_pkg::BACK_DUMP: begin
            rd_active = 1'b1;
         end
         default: begin
            pop = 1'b0;
         end
      endcase
   end

   // Chunk sizing for the read issued this cycle.
   always_comb begin
      if (remain_ff >= HELD_W'(clrc_pkg::LANES)) begin
         take = BCW'(clrc_pkg::LANES);
      end else begin
         take = remain_ff[BCW-1:0];
      end
      last_chunk = (remain_ff <= HELD_W'(clrc_pkg::LANES));
      held_sum   = {1'b0, held_ff} + (HELD_W + 1)'(head_cmd.count);
   end

   always_comb begin
      wr_pos_in  = wr_pos_ff;
      held_in    = held_ff;
      rd_base_in = rd_base_ff;
      remain_in  = remain_ff;
      if (wr_active) begin
         wr_pos_in = wr_pos_ff + POS_W'(head_cmd.count);
         if (held_sum > (HELD_W + 1)'(clrc_pkg::RING_BYTES)) begin
            held_in = HELD_W'(clrc_pkg::RING_BYTES);
         end else begin
            held_in = held_sum[HELD_W-1:0];
         end
      end
      if (dump_start) begin
         // Oldest byte sits at the write position once the ring has wrapped.
         if (held_ff == HELD_W'(clrc_pkg::RING_BYTES)) begin
            rd_base_in = wr_pos_ff;
         end else begin
            rd_base_in = '0;
         end
         remain_in = held_ff;
      end else if (rd_active) begin
         rd_base_in = rd_base_ff + POS_W'(clrc_pkg::LANES);
         remain_in  = remain_ff - HELD_W'(take);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= clrc_pkg::BACK_IDLE;
         wr_pos_ff    <= '0;
         held_ff      <= '0;
         remain_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wr_pos_ff    <= wr_pos_in;
         held_ff      <= held_in;
         remain_ff    <= remain_in;
         out_valid_ff <= rd_active;
      end
   end

   always_ff @(posedge clock) begin
      rd_base_ff <= rd_base_in;
      if (rd_active) begin
         chunk_lo_ff <= rd_base_ff[LANE_W-1:0];
         take_ff     <= take;
         last_ff     <= last_chunk;
      end
   end

   // One bank per byte lane; a byte at ring position p lives in lane p mod 8.
   for (genvar b = 0; b < clrc_pkg::LANES; b++) begin : g_bank
      localparam logic [LANE_W-1:0] LANE = LANE_W'(b);

      logic [7:0]              bank_mem_ff [clrc_pkg::ROWS];
      logic [LANE_W-1:0]       wr_idx;
      logic [POS_W-1:0]        wr_lane_pos;
      logic                    wr_en;
      logic [7:0]              wr_byte;
      logic [LANE_W-1:0]       rd_idx;
      logic [POS_W-1:0]        rd_lane_pos;

      always_comb begin
         wr_idx      = LANE - wr_pos_ff[LANE_W-1:0];
         wr_lane_pos = wr_pos_ff + POS_W'(wr_idx);
         wr_en       = wr_active && (BCW'(wr_idx) < head_cmd.count);
         wr_byte     = head_cmd.data[8*wr_idx +: 8];
         rd_idx      = LANE - rd_base_ff[LANE_W-1:0];
         rd_lane_pos = rd_base_ff + POS_W'(rd_idx);
      end

      always_ff @(posedge clock) begin
         if (wr_en) begin
            bank_mem_ff[wr_lane_pos[POS_W-1:LANE_W]] <= wr_byte;
         end
      end

      always_ff @(posedge clock) begin
         if (rd_active) begin
            rd_q_ff[b] <= bank_mem_ff[rd_lane_pos[POS_W-1:LANE_W]];
         end
      end
   end

   // Rotate the lanes back into age order and zero bytes past the chunk length.
   always_comb begin
      logic [LANE_W-1:0] lane;
      rsp_payload.chunk_data = '0;
      for (int i = 0; i < clrc_pkg::LANES; i++) begin
         lane = chunk_lo_ff + LANE_W'(i);
         if (BCW'(i) < take_ff) begin
            rsp_payload.chunk_data[8*i +: 8] = rd_q_ff[lane];
         end
      end
      rsp_payload.chunk_bytes = take_ff;
      rsp_payload.chunk_last  = last_ff;
   end

   assign rsp_valid = out_valid_ff;

endmodule

// ----- hw/rtl/console_log_ring_capture.sv -----
// Top level of the console log ring capture block.
//
//   Channel   Ports                          Handshake
//   --------  -----------------------------  ------------------------------------
//   request   start, busy, req_payload       item taken when start and not busy
//   result    rsp_valid, rsp_payload         one-cycle strobe, cannot be held off
//
// An append item is taken every cycle while the command queue has room and is written
// into the ring when it reaches the head of the queue and the ring engine is idle, so
// appends sustain one item per cycle while no dump holds the engine. A dump of N held
// bytes keeps the ring engine for one step to start the dump and one bank read per
// chunk, and its chunks appear on consecutive cycles, each registered after its bank
// read; items that arrive meanwhile wait in the four-entry queue, and busy rises only
// when that queue is full. Reset is synchronous; the held byte count guards every read,
// so the ring storage needs no clearing pass. The receiver cannot stall results.
module console_log_ring_capture (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  clrc_pkg::clrc_req_type req_payload,
   output logic                   rsp_valid,
   output clrc_pkg::clrc_rsp_type rsp_payload
);

   clrc_pkg::clrc_queue_status_type queue_status;
   clrc_pkg::clrc_cmd_type          push_cmd;
   clrc_pkg::clrc_cmd_type          head_cmd;
   logic                            push;
   logic                            pop;

   // The front end classifies each item: dumps pass as they are, append counts are
   // clamped to eight bytes, and appends of zero bytes are accepted and discarded.
   clrc_front u_front (
      .start        (start),
      .req_payload  (req_payload),
      .queue_status (queue_status),
      .busy         (busy),
      .push         (push),
      .push_cmd     (push_cmd)
   );

   // The queue decouples the front end from the ring engine, so a long dump does not
   // stop new items from being taken until the queue fills.
   clrc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .status   (queue_status)
   );

   // The ring engine owns the byte-lane banks, the write position and the held count.
   // It writes each append into the banks as it pops it, and streams a dump one chunk per cycle.
   clrc_back u_back (
      .clock        (clock),
      .reset        (reset),
      .queue_status (queue_status),
      .head_cmd     (head_cmd),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_payload  (rsp_payload)
   );

endmodule

// ----- hw/rtl/clrc_checker.sv -----
// Port-level checks for the console log ring capture block, bound to its top level.
module clrc_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   busy,
   input logic                   rsp_valid,
   input clrc_pkg::clrc_rsp_type rsp_payload
);

   // Reset leaves the queue empty and no dump in flight.
   a_reset_quiet: assert property (@(posedge clock) reset |=> (!busy && !rsp_valid))
      else $error("busy or result strobe right after reset");

   // The chunks of one dump come out on consecutive cycles.
   a_chunks_contiguous: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_payload.chunk_last) |=> rsp_valid)
      else $error("gap inside a dump");

   // Only the final chunk of a dump may be short.
   a_full_chunks: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_payload.chunk_last) |-> (rsp_payload.chunk_bytes == 4'd8))
      else $error("short chunk before the last one");

   // Every chunk carries one to eight bytes.
   a_chunk_size: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_payload.chunk_bytes != 4'd0) && (rsp_payload.chunk_bytes <= 4'd8)))
      else $error("chunk byte count out of range");

   // In a one-byte chunk, the bytes past the first are zero.
   a_chunk_padding: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_payload.chunk_bytes == 4'd1))
         |-> (rsp_payload.chunk_data[63:8] == 56'd0))
      else $error("nonzero padding in a one-byte chunk");

endmodule

bind console_log_ring_capture clrc_checker u_clrc_checker (.*);

// ----- test/console_log_ring_capture_tb.sv -----
// Self-checking testbench for the console log ring capture block.
module console_log_ring_capture_tb;
   timeunit 1ns;
   timeprecision 1ps;

   // Cycles with neither an item taken nor an owed chunk seen before the run is
   // abandoned. A full dump is 64 chunks and the queue holds four commands, so a
   // correct block never comes anywhere near this.
   localparam int STALL_LIMIT   = 2000;
   // Quiet cycles after the last expected chunk, to catch stray chunks.
   localparam int SETTLE_CYCLES = 20;
   localparam int RANDOM_ITEMS  = 144;
   // The tail of the random part runs with start held high throughout.
   localparam int STEADY_ITEMS  = 30;

   // A directed row: the item, and how its result is known. With from_model set the
   // chunks come from the shadow ring below; otherwise want_count (0 or 1) chunks
   // are typed into the row.
   typedef struct {
      clrc_pkg::clrc_req_type item;
      bit                     from_model;
      int                     want_count;
      clrc_pkg::clrc_rsp_type want;
   } directed_row_type;

   logic                   clock       = 1'b0;
   logic                   reset       = 1'b1;
   logic                   start       = 1'b0;
   logic                   busy;
   clrc_pkg::clrc_req_type req_payload = '0;
   logic                   rsp_valid;
   clrc_pkg::clrc_rsp_type rsp_payload;

   // Shadow copy of the ring, kept in step with every accepted item.
   logic [7:0]                 shadow_ring [clrc_pkg::RING_BYTES];
   logic [clrc_pkg::POS_W-1:0] shadow_wpos;
   int                         shadow_held;

   clrc_pkg::clrc_rsp_type dump_chunks [$];     // chunks worked out for the latest item
   clrc_pkg::clrc_rsp_type pending_chunks [$];  // chunks still owed by the block
   directed_row_type       directed_rows [$];

   int mismatches   = 0;
   int stall_cycles = 0;

   always #5 clock = ~clock;

   console_log_ring_capture i_dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

   // Applies one accepted item to the shadow ring. An append stores up to eight bytes
   // at the write position and wraps; a dump leaves the ring alone and fills
   // dump_chunks with the held bytes, oldest first, eight to a chunk.
   function automatic void shadow_ring_apply(input clrc_pkg::clrc_req_type item);
      int                     lanes;
      int                     first;
      int                     done;
      int                     take;
      clrc_pkg::clrc_rsp_type chunk;
      dump_chunks.delete();
      if (item.action == clrc_pkg::ACTION_APPEND) begin
         lanes = (item.byte_count > 4'd8) ? 8 : int'(item.byte_count);
         for (int i = 0; i < lanes; i++) begin
            shadow_ring[(int'(shadow_wpos) + i) % clrc_pkg::RING_BYTES] =
               item.data_bytes[8*i +: 8];
         end
         shadow_wpos = shadow_wpos + clrc_pkg::POS_W'(lanes);
         shadow_held = (shadow_held + lanes > clrc_pkg::RING_BYTES) ? clrc_pkg::RING_BYTES
                                                                    : shadow_held + lanes;
      end else begin
         // Until the ring has wrapped once, the oldest byte sits at the bottom.
         first = (shadow_held < clrc_pkg::RING_BYTES) ? 0 : int'(shadow_wpos);
         done  = 0;
         while (done < shadow_held) begin
            take  = (shadow_held - done > 8) ? 8 : shadow_held - done;
            chunk = '0;
            for (int i = 0; i < take; i++) begin
               chunk.chunk_data[8*i +: 8] =
                  shadow_ring[(first + done + i) % clrc_pkg::RING_BYTES];
            end
            done              = done + take;
            chunk.chunk_bytes = clrc_pkg::BYTE_CNT_W'(take);
            chunk.chunk_last  = (done >= shadow_held);
            dump_chunks.push_back(chunk);
         end
      end
   endfunction

   function automatic directed_row_type directed_row(
         input clrc_pkg::clrc_action_type             action,
         input logic [63:0]                           data,
         input logic [clrc_pkg::BYTE_CNT_W-1:0]       count,
         input bit                                    from_model,
         input int                                    want_count,
         input logic [63:0]                           want_data,
         input logic [clrc_pkg::BYTE_CNT_W-1:0]       want_bytes,
         input logic                                  want_last);
      directed_row_type row;
      row.item.action       = action;
      row.item.data_bytes   = data;
      row.item.byte_count   = count;
      row.from_model        = from_model;
      row.want_count        = want_count;
      row.want.chunk_data   = want_data;
      row.want.chunk_bytes  = want_bytes;
      row.want.chunk_last   = want_last;
      return row;
   endfunction

   // Offers one item and returns at the edge that takes it. Before the item the
   // sender may go quiet for a short burst, so gaps land on every phase of a dump.
   task automatic offer_item(input clrc_pkg::clrc_req_type item, input bit allow_gap);
      if (allow_gap && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_payload <= item;
      start       <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // Random items are mostly appends, half of them full eight-byte writes so the ring
   // fills and wraps within the run; the rest carry any count, zero and oversized
   // counts included. About one item in ten is a dump.
   function automatic clrc_pkg::clrc_req_type random_item();
      clrc_pkg::clrc_req_type item;
      item.action     = ($urandom_range(0, 9) == 0) ? clrc_pkg::ACTION_DUMP
                                                    : clrc_pkg::ACTION_APPEND;
      item.data_bytes = {$urandom, $urandom};
      item.byte_count = ($urandom_range(0, 1) == 0)
                           ? 4'd8 : clrc_pkg::BYTE_CNT_W'($urandom_range(0, 15));
      return item;
   endfunction

   // Every chunk the block shows is taken at the edge that ends its strobe cycle and
   // is checked against the oldest chunk still owed.
   always @(posedge clock) begin
      clrc_pkg::clrc_rsp_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_chunks.size() == 0) begin
            $error("chunk with nothing pending: data %h bytes %0d last %0b",
                   rsp_payload.chunk_data, rsp_payload.chunk_bytes, rsp_payload.chunk_last);
            mismatches++;
         end else begin
            want = pending_chunks.pop_front();
            if (rsp_payload.chunk_data !== want.chunk_data) begin
               $error("chunk_data: expected %h, got %h", want.chunk_data,
                      rsp_payload.chunk_data);
               mismatches++;
            end
            if (rsp_payload.chunk_bytes !== want.chunk_bytes) begin
               $error("chunk_bytes: expected %0d, got %0d", want.chunk_bytes,
                      rsp_payload.chunk_bytes);
               mismatches++;
            end
            if (rsp_payload.chunk_last !== want.chunk_last) begin
               $error("chunk_last: expected %0b, got %0b", want.chunk_last,
                      rsp_payload.chunk_last);
               mismatches++;
            end
         end
      end
   end

   // Watchdog: a taken item or a chunk that was owed counts as progress; stray
   // chunks do not, so a block stuck strobing cannot keep the run alive.
   always @(posedge clock) begin
      if (reset || (start && !busy) ||
          (rsp_valid === 1'b1 && pending_chunks.size() != 0)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin : watchdog
      wait (stall_cycles >= STALL_LIMIT);
      $display("console_log_ring_capture_tb: errors");
      $finish;
   end

   initial begin : stimulus
      clrc_pkg::clrc_req_type item;
      for (int i = 0; i < clrc_pkg::RING_BYTES; i++) begin
         shadow_ring[i] = 8'h00;
      end
      shadow_wpos = '0;
      shadow_held = 0;

      // Directed part. Appends never answer; dumps on an empty ring give nothing.
      directed_rows.push_back(directed_row(clrc_pkg::ACTION_DUMP, '1, 4'd8,
                                           0, 0, '0, '0, 1'b0));
      // A zero count must leave the ring empty.
      directed_rows.push_back(directed_row(clrc_pkg::ACTION_APPEND, '1, 4'd0,
                                           0, 0, '0, '0, 1'b0));
      directed_rows.push_back(directed_row(clrc_pkg::ACTION_DUMP, '0, 4'd0,
                                           0, 0, '0, '0, 1'b0));
      // Eight bytes then a dump: exactly one full, final chunk with the same bytes.
      directed_rows.push_back(directed_row(clrc_pkg::ACTION_APPEND, 64'h0123_4567_89AB_CDEF,
                                           4'd8, 0, 0, '0, '0, 1'b0));
      directed_rows.push_back(directed_row(clrc_pkg::ACTION_DUMP, '0, 4'd1, 0, 1,
                                           64'h0123_4567_89AB_CDEF, 4'd8, 1'b1));
      // The largest count stores eight bytes only.
      directed_rows.push_back(directed_row(clrc_pkg::ACTION_APPEND, '1, 4'd15,
                                           0, 0, '0, '0, 1'b0));
      directed_rows.push_back(directed_row(clrc_pkg::ACTION_DUMP, '0, 4'd15,
                                           1, 0, '0, '0, 1'b0));
      // Single byte and an oversized count of nine: the last chunk is a remainder.
      directed_rows.push_back(directed_row(clrc_pkg::ACTION_APPEND, 64'h0000_0000_0000_00A5,
                                           4'd1, 0, 0, '0, '0, 1'b0));
      directed_rows.push_back(directed_row(clrc_pkg::ACTION_APPEND, '0, 4'd9,
                                           0, 0, '0, '0, 1'b0));
      directed_rows.push_back(directed_row(clrc_pkg::ACTION_DUMP, '1, 4'd8,
                                           1, 0, '0, '0, 1'b0));
      // Lanes beyond the count must not reach the ring.
      directed_rows.push_back(directed_row(clrc_pkg::ACTION_APPEND, '1, 4'd3,
                                           0, 0, '0, '0, 1'b0));
      directed_rows.push_back(directed_row(clrc_pkg::ACTION_APPEND, 64'h8000_0000_0000_0001,
                                           4'd7, 0, 0, '0, '0, 1'b0));
      directed_rows.push_back(directed_row(clrc_pkg::ACTION_APPEND, 64'h7FFF_FFFF_FFFF_FF5A,
                                           4'd2, 0, 0, '0, '0, 1'b0));
      directed_rows.push_back(directed_row(clrc_pkg::ACTION_DUMP, '0, 4'd0,
                                           1, 0, '0, '0, 1'b0));
      // Back-to-back dumps must give the same bytes twice.
      directed_rows.push_back(directed_row(clrc_pkg::ACTION_DUMP, '1, 4'd15,
                                           1, 0, '0, '0, 1'b0));

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) begin
         offer_item(directed_rows[r].item, 1'b1);
         shadow_ring_apply(directed_rows[r].item);
         if (directed_rows[r].from_model) begin
            foreach (dump_chunks[c]) pending_chunks.push_back(dump_chunks[c]);
         end else if (directed_rows[r].want_count != 0) begin
            pending_chunks.push_back(directed_rows[r].want);
         end
      end

      // Random part, closed by one dump so the state after the last wrap is read out.
      for (int n = 0; n <= RANDOM_ITEMS; n++) begin
         item = random_item();
         if (n == RANDOM_ITEMS) item.action = clrc_pkg::ACTION_DUMP;
         offer_item(item, n < RANDOM_ITEMS - STEADY_ITEMS);
         shadow_ring_apply(item);
         foreach (dump_chunks[c]) pending_chunks.push_back(dump_chunks[c]);
      end
      start <= 1'b0;

      while (pending_chunks.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (mismatches == 0) begin
         $display("console_log_ring_capture_tb: clean");
      end else begin
         $display("console_log_ring_capture_tb: errors");
      end
      $finish;
   end

endmodule

// ----- files.f -----
hw/rtl/clrc_pkg.sv
hw/rtl/clrc_front.sv
hw/rtl/clrc_queue.sv
hw/rtl/clrc_back.sv
hw/rtl/console_log_ring_capture.sv
hw/rtl/clrc_checker.sv
test/console_log_ring_capture_tb.sv
